FILE: rtl/core/tohb_pkg.sv
// Shared request, status, state and result types for the time-ordered history buffer.
package tohb_pkg;

    typedef enum logic [2:0] {
        REQ_ADD        = 3'd0,
        REQ_RM_OLDEST  = 3'd1,
        REQ_RM_BEFORE  = 3'd2,
        REQ_RM_NEWEST  = 3'd3,
        REQ_CLEAR      = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_APPENDED       = 4'd0,
        ST_APPENDED_EVICT = 4'd1,
        ST_REPLACED       = 4'd2,
        ST_INSERTED       = 4'd3,
        ST_INSERTED_EVICT = 4'd4,
        ST_PREPENDED      = 4'd5,
        ST_REFUSED        = 4'd6,
        ST_REMOVED        = 4'd7,
        ST_READ_OK        = 4'd8,
        ST_READ_BAD       = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_NEWEST,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_PURGE,
        S_DONE
    } ctrl_state_t;

    localparam int TIME_BITS  = 32;
    localparam int OUT_PBITS  = 64;
    localparam int COUNT_BITS = 5;

    typedef struct packed {
        status_t                 status;
        logic [TIME_BITS-1:0]    rtime;
        logic [OUT_PBITS-1:0]    rpayload;
        logic [COUNT_BITS-1:0]   count;
    } res_t;

endpackage

FILE: rtl/core/tohb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tohb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/tohb_ctrl.sv
// Request sequencer: search, shift and window bookkeeping over the entry RAM.
module tohb_ctrl #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64,
    parameter int AW           = $clog2(DEPTH),
    parameter int DW           = tohb_pkg::TIME_BITS + PAYLOAD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tohb_pkg::req_t                 req_type,
    input  logic [tohb_pkg::TIME_BITS-1:0] time_stamp,
    input  logic [PAYLOAD_BITS-1:0]        payload,
    input  logic [7:0]                     remove_count,
    input  logic [7:0]                     read_index,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tohb_pkg::res_t                 res,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [DW-1:0]                  ram_wdata,
    output logic                           ram_re,
    output logic [AW-1:0]                  ram_raddr,
    input  logic [DW-1:0]                  ram_rdata
);

    import tohb_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    ctrl_state_t             state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           oldest_reg, oldest_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           ins_reg, ins_next;
    status_t                 status_reg, status_next;
    logic [TIME_BITS-1:0]    rd_time_reg, rd_time_next;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg, rd_pay_next;

    req_t                    rtype_reg;
    logic [TIME_BITS-1:0]    t_reg;
    logic [PAYLOAD_BITS-1:0] p_reg;
    logic [7:0]              n_reg;
    logic [7:0]              idx_reg;

    logic                    full;
    logic                    accept;
    logic [TIME_BITS-1:0]    rd_t;
    logic [PAYLOAD_BITS-1:0] rd_p;

    // Physical slot of a logical position (0 = oldest, DEPTH wraps to the oldest slot).
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW+1)'(oldest_reg) + (CW+1)'(pos);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Slot one place before a logical position.
    function automatic logic [AW-1:0] slot_prev(input logic [CW-1:0] pos);
        logic [AW-1:0] s;
        s = slot_of(pos);
        return (s == '0) ? AW'(DEPTH - 1) : s - 1'b1;
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign rd_t    = ram_rdata[DW-1:PAYLOAD_BITS];
    assign rd_p    = ram_rdata[PAYLOAD_BITS-1:0];

    assign res_valid    = (state_reg == S_DONE);
    assign res.status   = status_reg;
    assign res.rtime    = (status_reg == ST_READ_OK) ? rd_time_reg : '0;
    assign res.rpayload = (status_reg == ST_READ_OK) ? OUT_PBITS'(rd_pay_reg) : '0;
    assign res.count    = COUNT_BITS'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            oldest_reg <= '0;
            pos_reg    <= '0;
            ins_reg    <= '0;
            status_reg <= ST_REMOVED;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            pos_reg    <= pos_next;
            ins_reg    <= ins_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time_reg <= rd_time_next;
        rd_pay_reg  <= rd_pay_next;
        if (accept)
        begin
            rtype_reg <= req_type;
            t_reg     <= time_stamp;
            p_reg     <= payload;
            n_reg     <= remove_count;
            idx_reg   <= read_index;
        end
    end

    always_comb
    begin
        logic [CW-1:0] k;
        logic [CW-1:0] shift_start;

        state_next   = state_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        pos_next     = pos_reg;
        ins_next     = ins_reg;
        status_next  = status_reg;
        rd_time_next = rd_time_reg;
        rd_pay_next  = rd_pay_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_of(count_reg);
        ram_wdata    = {t_reg, p_reg};
        ram_re       = 1'b0;
        ram_raddr    = slot_of(pos_reg);

        k = (XW'(n_reg) >= XW'(count_reg)) ? count_reg : CW'(n_reg);
        // A full store evicts the oldest entry instead of moving it back.
        shift_start = full ? CW'(1) : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                state_next  = S_DONE;
                status_next = ST_REMOVED;
                case (rtype_reg)
                    REQ_ADD:
                    begin
                        if (count_reg == '0)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = slot_of(count_reg);
                            count_next  = count_reg + 1'b1;
                            status_next = ST_APPENDED;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = slot_of(count_reg - 1'b1);
                            state_next = S_NEWEST;
                        end
                    end
                    REQ_RM_OLDEST:
                    begin
                        oldest_next = slot_of(k);
                        count_next  = count_reg - k;
                    end
                    REQ_RM_BEFORE:
                    begin
                        if (count_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = slot_of('0);
                            state_next = S_PURGE;
                        end
                    end
                    REQ_RM_NEWEST:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        count_next  = '0;
                        oldest_next = '0;
                    end
                    REQ_READ:
                    begin
                        if (XW'(idx_reg) < XW'(count_reg))
                        begin
                            ram_re      = 1'b1;
                            ram_raddr   = slot_of(CW'(idx_reg));
                            status_next = ST_READ_OK;
                            state_next  = S_NEWEST;
                        end
                        else
                        begin
                            status_next = ST_READ_BAD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_READ_BAD;
                    end
                endcase
            end

            S_NEWEST:
            begin
                if (rtype_reg == REQ_READ)
                begin
                    rd_time_next = rd_t;
                    rd_pay_next  = rd_p;
                    state_next   = S_DONE;
                end
                else if (t_reg > rd_t)
                begin
                    // Later than the newest: append, advance the window when full.
                    ram_we     = 1'b1;
                    ram_waddr  = slot_of(count_reg);
                    state_next = S_DONE;
                    if (full)
                    begin
                        oldest_next = slot_of(CW'(1));
                        status_next = ST_APPENDED_EVICT;
                    end
                    else
                    begin
                        count_next  = count_reg + 1'b1;
                        status_next = ST_APPENDED;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_of('0);
                    pos_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_t == t_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot_of(pos_reg);
                    status_next = ST_REPLACED;
                    state_next  = S_DONE;
                end
                else if (t_reg < rd_t)
                begin
                    ins_next = pos_reg;
                    if (pos_reg == '0)
                    begin
                        state_next = S_DONE;
                        if (full)
                        begin
                            status_next = ST_REFUSED;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = slot_prev('0);
                            oldest_next = slot_prev('0);
                            count_next  = count_reg + 1'b1;
                            status_next = ST_PREPENDED;
                        end
                    end
                    else if (shift_start < pos_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_of(shift_start);
                        pos_next   = shift_start;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    // Read ahead so that one entry is compared every cycle.
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(pos_reg + 1'b1);
                    pos_next  = pos_reg + 1'b1;
                end
            end

            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_prev(pos_reg);
                ram_wdata = ram_rdata;
                if ((pos_reg + 1'b1) < ins_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(pos_reg + 1'b1);
                    pos_next  = pos_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_prev(ins_reg);
                state_next = S_DONE;
                if (full)
                begin
                    status_next = ST_INSERTED_EVICT;
                end
                else
                begin
                    oldest_next = slot_prev('0);
                    count_next  = count_reg + 1'b1;
                    status_next = ST_INSERTED;
                end
            end

            S_PURGE:
            begin
                if (rd_t < t_reg)
                begin
                    oldest_next = slot_of(CW'(1));
                    count_next  = count_reg - 1'b1;
                    if (count_reg > CW'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_of(CW'(1));
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/time_ordered_history_buffer.sv
// Top level of the time-ordered history buffer: stream ports, entry RAM and result register.
//
// Requests arrive on the s_ group; the kind of request (add, remove oldest n,
// remove before time, remove newest, clear, read) travels in s_tuser, the
// operands in s_tdata. Every request gives exactly one result on the m_ group:
// the status code in m_tuser, the entry read and the count after the request
// in m_tdata. Requests are handled one at a time.
// Clear, remove oldest n, remove newest and an out-of-range read do not use the
// RAM read port; a valid read reads one entry. An add into an empty store writes
// at once; otherwise it reads the newest entry, appends after it when later, and
// else searches and moves entries, where every search step and every move is one
// access of the entry RAM's read port. Remove before time reads the entries from
// the oldest on, one RAM read per entry examined.
// Reset empties the store at once; the RAM contents are not cleared and are
// never read before being written. A result waits in the output register while
// m_tready is low; the next request is still accepted and worked on, and its
// result waits inside the sequencer until the register frees up.
module time_ordered_history_buffer #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // time_stamp, payload, remove_count, read_index
    input  logic [2:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // read_time, read_payload, entry_count, zero fill
    output logic [3:0]   m_tuser    // status
);

    import tohb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int DW = TIME_BITS + PAYLOAD_BITS;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg;

    tohb_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .req_type     (req_t'(s_tuser)),
        .time_stamp   (s_tdata[31:0]),
        .payload      (s_tdata[32 +: PAYLOAD_BITS]),
        .remove_count (s_tdata[103:96]),
        .read_index   (s_tdata[111:104]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    tohb_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Load a new result when the register is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.rpayload, out_reg.rtime};

    a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != ST_READ_OK)
        |-> (out_reg.rtime == '0) && (out_reg.rpayload == '0))
        else $error("entry fields not zero on a non-read result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !res_valid)
        else $error("ready while a result is still pending in the sequencer");

endmodule

FILE: sim/tb_time_ordered_history_buffer.sv
// Testbench for the time-ordered history buffer: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module tb_time_ordered_history_buffer;

    import tohb_pkg::*;

    localparam int          STORE_DEPTH    = 16;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_OFF_LEN   = 400;
    localparam logic [2:0]  REQ_RESERVED_A = 3'd6;
    localparam logic [2:0]  REQ_RESERVED_B = 3'd7;

    typedef struct packed {
        logic [31:0] stamp;
        logic [63:0] data;
    } entry_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;   // time_stamp, payload, remove_count, read_index
    logic [2:0]   s_tuser  = '0;   // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;         // read_time, read_payload, entry_count, zero fill
    logic [3:0]   m_tuser;         // status

    entry_t      stored_entries[$];
    res_t        predicted_results[$];
    int unsigned failures          = 0;
    bit          idle_enable       = 1'b1;
    int unsigned hold_off_request  = 0;
    logic [31:0] stamp_base        = '0;

    time_ordered_history_buffer #(
        .DEPTH        (STORE_DEPTH),
        .PAYLOAD_BITS (64)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Apply one request to the sorted entry list and return the result it gives.
    function automatic res_t apply_request(input logic [2:0] kind, input logic [31:0] stamp,
                                           input logic [63:0] data, input logic [7:0] drop_n,
                                           input logic [7:0] slot_idx);
        res_t   r;
        entry_t e;
        int     pos;
        int     n_drop;
        bit     found;
        bit     full;
        r       = '0;
        e.stamp = stamp;
        e.data  = data;
        found   = 1'b0;
        full    = (stored_entries.size() == STORE_DEPTH);
        case (kind)
            REQ_ADD:
            begin
                if (stored_entries.size() == 0 || stamp > stored_entries[$].stamp)
                begin
                    // newer than everything: append, dropping the oldest when full
                    if (full)
                    begin
                        void'(stored_entries.pop_front());
                        r.status = ST_APPENDED_EVICT;
                    end
                    else
                        r.status = ST_APPENDED;
                    stored_entries.push_back(e);
                end
                else
                begin
                    pos = stored_entries.size();
                    for (int k = 0; k < stored_entries.size(); k++)
                    begin
                        if (stored_entries[k].stamp == stamp)
                        begin
                            stored_entries[k].data = data;
                            r.status = ST_REPLACED;
                            found = 1'b1;
                            break;
                        end
                        if (stamp < stored_entries[k].stamp)
                        begin
                            pos = k;
                            break;
                        end
                    end
                    if (!found)
                    begin
                        if (pos == 0)
                        begin
                            if (full)
                                r.status = ST_REFUSED;
                            else
                            begin
                                stored_entries.push_front(e);
                                r.status = ST_PREPENDED;
                            end
                        end
                        else
                        begin
                            stored_entries.insert(pos, e);
                            if (full)
                            begin
                                void'(stored_entries.pop_front());
                                r.status = ST_INSERTED_EVICT;
                            end
                            else
                                r.status = ST_INSERTED;
                        end
                    end
                end
            end
            REQ_RM_OLDEST:
            begin
                n_drop = (drop_n > stored_entries.size()) ? stored_entries.size() : drop_n;
                repeat (n_drop) void'(stored_entries.pop_front());
                r.status = ST_REMOVED;
            end
            REQ_RM_BEFORE:
            begin
                while (stored_entries.size() > 0 && stored_entries[0].stamp < stamp)
                    void'(stored_entries.pop_front());
                r.status = ST_REMOVED;
            end
            REQ_RM_NEWEST:
            begin
                if (stored_entries.size() > 0)
                    void'(stored_entries.pop_back());
                r.status = ST_REMOVED;
            end
            REQ_CLEAR:
            begin
                stored_entries.delete();
                r.status = ST_REMOVED;
            end
            REQ_READ:
            begin
                if (slot_idx < stored_entries.size())
                begin
                    r.status   = ST_READ_OK;
                    r.rtime    = stored_entries[slot_idx].stamp;
                    r.rpayload = stored_entries[slot_idx].data;
                end
                else
                    r.status = ST_READ_BAD;
            end
            default:
                r.status = ST_READ_BAD;
        endcase
        r.count = COUNT_BITS'(stored_entries.size());
        return r;
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [31:0] stamp,
                                input logic [63:0] data, input logic [7:0] drop_n,
                                input logic [7:0] slot_idx);
        if (idle_enable && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {slot_idx, drop_n, data, stamp};
        do @(posedge clk); while (!s_tready);
        predicted_results.push_back(apply_request(kind, stamp, data, drop_n, slot_idx));
    endtask

    function automatic logic [31:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20 && stored_entries.size() > 0)
            return stored_entries[$urandom_range(0, stored_entries.size() - 1)].stamp;
        if (r < 22)
            return 32'h0;
        if (r < 24)
            return 32'hFFFF_FFFF;
        if (r < 29)
            return $urandom;
        return stamp_base + $urandom_range(0, 40);
    endfunction

    // Half of the requests are adds near a slowly advancing time, so the store fills and evicts often.
    task automatic send_random_request();
        int          r;
        logic [2:0]  kind;
        logic [31:0] stamp;
        logic [63:0] data;
        logic [7:0]  drop_n;
        logic [7:0]  slot_idx;
        r = $urandom_range(0, 99);
        if (r < 50)
            kind = REQ_ADD;
        else if (r < 72)
            kind = REQ_READ;
        else if (r < 79)
            kind = REQ_RM_OLDEST;
        else if (r < 86)
            kind = REQ_RM_BEFORE;
        else if (r < 94)
            kind = REQ_RM_NEWEST;
        else if (r < 95)
            kind = REQ_CLEAR;
        else if (r < 97)
            kind = REQ_RESERVED_A;
        else
            kind = REQ_RESERVED_B;
        if (kind == REQ_RM_BEFORE && $urandom_range(0, 9) != 0)
            stamp = stamp_base - $urandom_range(0, 60);
        else
            stamp = pick_stamp();
        r = $urandom_range(0, 99);
        if (r < 3)
            data = '0;
        else if (r < 6)
            data = '1;
        else
            data = {$urandom, $urandom};
        drop_n   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        slot_idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
        send_request(kind, stamp, data, drop_n, slot_idx);
        stamp_base += $urandom_range(0, 6);
    endtask

    task automatic check_result();
        res_t want;
        if (predicted_results.size() == 0)
        begin
            $error("result with no request pending: status %0d", m_tuser);
            failures++;
        end
        else
        begin
            want = predicted_results.pop_front();
            if (m_tuser !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, m_tuser);
                failures++;
            end
            if (m_tdata[31:0] !== want.rtime)
            begin
                $error("read_time: expected %h, actual %h", want.rtime, m_tdata[31:0]);
                failures++;
            end
            if (m_tdata[95:32] !== want.rpayload)
            begin
                $error("read_payload: expected %h, actual %h", want.rpayload, m_tdata[95:32]);
                failures++;
            end
            if (m_tdata[100:96] !== want.count)
            begin
                $error("entry_count: expected %0d, actual %0d", want.count, m_tdata[100:96]);
                failures++;
            end
        end
    endtask

    initial
    begin : result_monitor
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            if (hold_off_request != 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_enable && $urandom_range(0, 99) < 9);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_empty_store();
        send_request(REQ_READ, '0, '0, '0, '0);
        send_request(REQ_RM_NEWEST, '0, '0, '0, '0);
        send_request(REQ_RM_BEFORE, 32'hFFFF_FFFF, '0, '0, '0);
    endtask

    // Fill to capacity, then hit every eviction, refusal and replace path.
    task automatic test_add_ordering();
        send_request(REQ_ADD, 32'd100, '1, '0, '0);
        send_request(REQ_ADD, 32'd1, '0, '0, '0);
        send_request(REQ_ADD, 32'd50, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'd100, {$urandom, $urandom}, '0, '0);
        for (int k = 0; k < 12; k++)
            send_request(REQ_ADD, 32'd200 + 32'(k) * 32'd10, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'hFFFF_FFFE, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'hFFFF_FFFF, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'd75, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'd0, {$urandom, $urandom}, '0, '0);
        send_request(REQ_ADD, 32'hFFFF_FFFF, '1, '0, '0);
    endtask

    task automatic test_read_and_remove();
        send_request(REQ_READ, '0, '0, '0, 8'd15);
        send_request(REQ_READ, '0, '0, '0, 8'hFF);
        send_request(REQ_RM_OLDEST, '0, '0, 8'd0, '0);
        send_request(REQ_RM_OLDEST, '0, '0, 8'd3, '0);
        send_request(REQ_RM_NEWEST, '0, '0, '0, '0);
        send_request(REQ_RM_BEFORE, 32'h8000_0000, '0, '0, '0);
        send_request(REQ_RM_OLDEST, '0, '0, 8'hFF, '0);
        send_request(REQ_RESERVED_B, '0, '0, '0, '0);
        send_request(REQ_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input bit calm);
        idle_enable = !calm;
        repeat (n_items) send_random_request();
        idle_enable = 1'b1;
    endtask

    // Hold the result side off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_off_request = HOLD_OFF_LEN;
        repeat (40) send_random_request();
    endtask

    initial
    begin
        stamp_base = $urandom_range(0, 1000);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_add_ordering();
        test_read_and_remove();
        test_random_traffic(350, 1'b1);
        test_backpressure();
        test_random_traffic(1000, 1'b0);
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tohb_pkg.sv
rtl/core/tohb_ram.sv
rtl/core/tohb_ctrl.sv
rtl/core/time_ordered_history_buffer.sv
sim/tb_time_ordered_history_buffer.sv
